// ===== rtl/min_tracking_stack_top_assert.svh =====
// Assertion macros for the min tracking stack checker.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef MIN_TRACKING_STACK_TOP_ASSERT_SVH
`define MIN_TRACKING_STACK_TOP_ASSERT_SVH

// Overlapping implication, sampled on the rising edge, off during reset.
`define MTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mts_pkg.sv =====
// Shared types and constants of the min tracking stack.
// No dependencies.
`default_nettype none

package mts_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int DATA_W      = 32;
  localparam int FILL_W      = 11;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } mts_status_t;

  // One stack entry: stored value and minimum of it and all entries below.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] run_min;
  } mts_entry_t;

  // Shift control broadcast along the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } mts_shift_t;

endpackage

`default_nettype wire

// ===== rtl/min_tracking_stack_top.sv =====
// Top level of the min tracking stack: handshake, fill count, result register.
// Depends on mts_pkg, mts_chain and mts_cell.
`default_nettype none

// Bounded stack of signed 32-bit values that also reports the smallest value
// held. Each item is a push (operation 0) or a pop (operation 1) and yields
// exactly one result: top value, minimum, fill count and status, with top and
// minimum reading 0 when the stack is empty. A push to a full stack and a pop
// from an empty one leave the stack as it is and are flagged in the status.
// One item is taken every clock cycle while the input is ready; its result
// appears in the output register in the cycle after acceptance, and the input
// stays ready while that register is empty or being drained in the same
// cycle. No item is taken while reset is held. The stack is a row
// of STACK_DEPTH cells that all shift down on a push and up on a pop, each
// cell holding a value and the running minimum of itself and everything
// below, so the answer is always in the top cell and no search is needed.
// Cell contents need no clearing after reset: only entries below the fill
// count are ever shown.

module min_tracking_stack_top (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            in_operation,
  input  wire signed [mts_pkg::DATA_W-1:0]   in_push_value,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [mts_pkg::DATA_W-1:0]  out_top_value,
  output logic signed [mts_pkg::DATA_W-1:0]  out_min_value,
  output logic [mts_pkg::FILL_W-1:0]     out_fill_count,
  output logic [mts_pkg::STATUS_W-1:0]   out_status
);
  import mts_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] top_r, top_nxt;
  logic signed [DATA_W-1:0] min_r, min_nxt;
  mts_status_t       status_r, status_nxt;

  logic              accept;
  logic              full;
  logic              empty;
  mts_shift_t        shift;
  mts_entry_t        push_entry;
  mts_entry_t        top_entry;
  mts_entry_t        second_entry;
  logic [CNT_W+FILL_W-1:0] count_ext;

  // Hold off new items during reset and while an untaken result sits in the
  // register.
  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == DEPTH_CNT);
  assign empty    = (count_r == '0);

  assign shift.push = accept && (in_operation == OP_PUSH) && !full;
  assign shift.pop  = accept && (in_operation == OP_POP) && !empty;

  // New entry: keep the running minimum below unless the value undercuts it.
  always_comb begin
    push_entry.value   = in_push_value;
    push_entry.run_min = in_push_value;
    if (!empty && (top_entry.run_min < in_push_value)) begin
      push_entry.run_min = top_entry.run_min;
    end
  end

  mts_chain u_chain (
    .clk          (clk),
    .shift        (shift),
    .push_entry   (push_entry),
    .top_entry    (top_entry),
    .second_entry (second_entry)
  );

  // Work out the result from the entry that will be on top after the item.
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    top_nxt       = top_r;
    min_nxt       = min_r;
    status_nxt    = status_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_DONE;
      priority if (shift.push) begin
        count_nxt = count_r + 1'b1;
        top_nxt   = push_entry.value;
        min_nxt   = push_entry.run_min;
      end else if (shift.pop) begin
        count_nxt = count_r - 1'b1;
        if (count_r == CNT_W'(1)) begin
          top_nxt = '0;
          min_nxt = '0;
        end else begin
          top_nxt = second_entry.value;
          min_nxt = second_entry.run_min;
        end
      end else if (in_operation == OP_PUSH) begin
        // Push refused: stack is full, report the unchanged top.
        status_nxt = ST_FULL;
        top_nxt    = top_entry.value;
        min_nxt    = top_entry.run_min;
      end else begin
        // Pop refused: stack is empty.
        status_nxt = ST_EMPTY;
        top_nxt    = '0;
        min_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    top_r    <= top_nxt;
    min_r    <= min_nxt;
    status_r <= status_nxt;
  end

  assign count_ext = {{FILL_W{1'b0}}, count_r};

  assign out_valid      = out_valid_r;
  assign out_top_value  = top_r;
  assign out_min_value  = min_r;
  assign out_fill_count = count_ext[FILL_W-1:0];
  assign out_status     = status_r;

endmodule

`default_nettype wire

// ===== rtl/mts_cell.sv =====
// One stack cell: holds an entry, takes its neighbour's entry on a shift.
// Depends on mts_pkg.
`default_nettype none

module mts_cell (
  input  wire                  clk,
  input  mts_pkg::mts_shift_t  shift,
  input  mts_pkg::mts_entry_t  from_above,
  input  mts_pkg::mts_entry_t  from_below,
  output mts_pkg::mts_entry_t  entry
);
  import mts_pkg::*;

  mts_entry_t entry_r;

  // Hold the entry when neither shift is requested.
  always_ff @(posedge clk) begin
    if (shift.push) begin
      entry_r <= from_above;
    end else if (shift.pop) begin
      entry_r <= from_below;
    end
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// ===== rtl/mts_chain.sv =====
// Row of stack cells; cell 0 is the top of the stack.
// Depends on mts_pkg and mts_cell.
`default_nettype none

module mts_chain (
  input  wire                  clk,
  input  mts_pkg::mts_shift_t  shift,
  input  mts_pkg::mts_entry_t  push_entry,
  output mts_pkg::mts_entry_t  top_entry,
  output mts_pkg::mts_entry_t  second_entry
);
  import mts_pkg::*;

  mts_entry_t cell_q [STACK_DEPTH];
  mts_entry_t below_q [STACK_DEPTH];
  mts_entry_t above_q [STACK_DEPTH];

  genvar i;
  generate
    for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
        assign above_q[i] = push_entry;
      end else begin : g_mid
        assign above_q[i] = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bot
        assign below_q[i] = '0;
      end else begin : g_up
        assign below_q[i] = cell_q[i+1];
      end
      mts_cell u_cell (
        .clk        (clk),
        .shift      (shift),
        .from_above (above_q[i]),
        .from_below (below_q[i]),
        .entry      (cell_q[i])
      );
    end
  endgenerate

  assign top_entry    = cell_q[0];
  assign second_entry = cell_q[1];

endmodule

`default_nettype wire

// ===== rtl/mts_checker.sv =====
// Port-level checker for the min tracking stack, bound to the top level.
// Depends on mts_pkg and min_tracking_stack_top_assert.svh.
`default_nettype none

`include "min_tracking_stack_top_assert.svh"

module mts_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire signed [mts_pkg::DATA_W-1:0] out_top_value,
  input wire signed [mts_pkg::DATA_W-1:0] out_min_value,
  input wire [mts_pkg::FILL_W-1:0]        out_fill_count,
  input wire [mts_pkg::STATUS_W-1:0]      out_status
);
  import mts_pkg::*;

  logic shown_empty;
  logic refused_pop;
  logic min_le_top;
  logic reads_zero;

  assign shown_empty = out_valid && (out_fill_count == '0);
  assign refused_pop = out_valid && (out_status == ST_EMPTY);
  assign min_le_top  = (out_min_value <= out_top_value);
  assign reads_zero  = (out_top_value == '0) && (out_min_value == '0);

  // Hold a result until it is taken.
  `MTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  // Minimum never exceeds the top value.
  `MTS_ASSERT_IMPL(a_min_le_top, out_valid && !shown_empty, min_le_top, "minimum above top")
  // Empty stack reads zero.
  `MTS_ASSERT_IMPL(a_empty_zero, shown_empty, reads_zero, "empty stack shows data")
  // A refused pop only happens on an empty stack.
  `MTS_ASSERT_IMPL(a_pop_empty, refused_pop, out_fill_count == '0, "pop refused with entries")

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_top_value  (out_top_value),
  .out_min_value  (out_min_value),
  .out_fill_count (out_fill_count),
  .out_status     (out_status)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for min_tracking_stack_top: directed, fill past full,
// back-pressure and random push/pop traffic against a shadow stack.
// Depends on mts_pkg and the min_tracking_stack_top RTL.
`timescale 1ns / 100ps

module tb;
  import mts_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RESET_LEN   = 12;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_CAP  = 100;

  // One expected result as seen at the output.
  typedef struct {
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] minv;
    logic [FILL_W-1:0]        fill;
    logic [STATUS_W-1:0]      status;
  } stack_view_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_operation = OP_PUSH;
  logic signed [DATA_W-1:0]   in_push_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b1;
  logic signed [DATA_W-1:0]   out_top_value;
  logic signed [DATA_W-1:0]   out_min_value;
  logic [FILL_W-1:0]          out_fill_count;
  logic [STATUS_W-1:0]        out_status;

  // Shadow copy of the stack: values and running minimum of each entry.
  logic signed [DATA_W-1:0]   shadow_val [STACK_DEPTH];
  logic signed [DATA_W-1:0]   shadow_min [STACK_DEPTH];
  int                         shadow_fill = 0;

  stack_view_t                pending_views [$];
  int                         mismatch_count = 0;
  int                         cycle_count = 0;

  // Idling controls, set by the test tasks.
  bit                         src_gaps_on = 1'b0;
  bit                         sink_gaps_on = 1'b0;
  int                         sink_hold_req = 0;

  min_tracking_stack_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_top_value  (out_top_value),
    .out_min_value  (out_min_value),
    .out_fill_count (out_fill_count),
    .out_status     (out_status)
  );

  always #CLK_HALF clk = ~clk;

  // Abort the run if it hangs; the limit is far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding",
               cycle_count, pending_views.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Print one line per mismatch (up to a cap) and count it.
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (mismatch_count < REPORT_CAP)
      $display("MISMATCH %s: got %0d expected %0d (cycle %0d)",
               what, $signed(got), $signed(want), cycle_count);
    mismatch_count++;
  endtask

  // Apply one item to the shadow stack and return the result it must give.
  // The running minimum of a new entry is the smaller of its value and the
  // running minimum below it; an equal value keeps the same minimum.
  function automatic stack_view_t step_shadow_stack(input logic op,
                                                    input logic signed [DATA_W-1:0] val);
    stack_view_t view;
    view.status = ST_DONE;
    if (op == OP_PUSH) begin
      if (shadow_fill >= STACK_DEPTH) begin
        view.status = ST_FULL;
      end else begin
        shadow_val[shadow_fill] = val;
        shadow_min[shadow_fill] = val;
        if (shadow_fill > 0 && shadow_min[shadow_fill-1] < val)
          shadow_min[shadow_fill] = shadow_min[shadow_fill-1];
        shadow_fill++;
      end
    end else if (shadow_fill == 0) begin
      view.status = ST_EMPTY;
    end else begin
      shadow_fill--;
    end
    if (shadow_fill > 0) begin
      view.top  = shadow_val[shadow_fill-1];
      view.minv = shadow_min[shadow_fill-1];
    end else begin
      view.top  = '0;
      view.minv = '0;
    end
    view.fill = FILL_W'(shadow_fill);
    return view;
  endfunction

  // Offer one item and hold it until the block takes it. in_ready is sampled
  // at the falling edge, where nothing can still be changing before the
  // next rising edge, so the handshake decision is free of races.
  task automatic send_item(input logic op, input logic signed [DATA_W-1:0] val);
    bit took;
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_push_value <= val;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    pending_views.push_back(step_shadow_stack(op, val));
  endtask

  // Drop valid and wait until every result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  // Mix of extremes, values close to zero (to get equal values often) and
  // fully random patterns.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(DATA_W-1){1'b1}}};
      1:       return {1'b1, {(DATA_W-1){1'b0}}};
      2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Result receiver: random stalls, or one long hold when a test asks.
  always begin
    @(posedge clk);
    if (sink_hold_req > 0) begin
      out_ready <= 1'b0;
      repeat (sink_hold_req) @(posedge clk);
      sink_hold_req = 0;
      out_ready <= 1'b1;
    end else if (sink_gaps_on && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      out_ready <= 1'b1;
    end
  end

  // Result checker: a result is taken at the next rising edge exactly when
  // valid and ready are both high at the falling edge before it.
  always @(negedge clk) begin : result_check
    stack_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        report_mismatch("unexpected result, top", out_top_value, '0);
      end else begin
        want = pending_views.pop_front();
        if (out_top_value !== want.top)
          report_mismatch("top_value", out_top_value, want.top);
        if (out_min_value !== want.minv)
          report_mismatch("min_value", out_min_value, want.minv);
        if (out_fill_count !== want.fill)
          report_mismatch("fill_count", DATA_W'(out_fill_count), DATA_W'(want.fill));
        if (out_status !== want.status)
          report_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
      end
    end
  end

  // Extremes, pops on an empty stack, equal values at the minimum, and a pop
  // carrying a non-zero value that must be ignored.
  task automatic test_directed();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    send_item(OP_POP,  '0);
    send_item(OP_POP,  {1'b0, {(DATA_W-1){1'b1}}});
    send_item(OP_PUSH, {1'b0, {(DATA_W-1){1'b1}}});
    send_item(OP_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
    send_item(OP_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, -1);
    send_item(OP_POP,  {DATA_W{1'b1}});
    send_item(OP_POP,  '0);
    send_item(OP_POP,  '0);
    send_item(OP_POP,  '0);
    send_item(OP_POP,  '0);
    send_item(OP_POP,  '0);
    send_item(OP_PUSH, 10);
    send_item(OP_PUSH, 12);
    send_item(OP_PUSH, 10);
    send_item(OP_PUSH, 11);
    send_item(OP_POP,  '0);
    send_item(OP_POP,  '0);
    send_item(OP_POP,  '0);
    send_item(OP_POP,  '0);
    send_item(OP_POP,  '0);
    wait_drained();
  endtask

  // Push until full and beyond (ignored pushes), then pop part of the way
  // back down.
  task automatic test_fill_and_drain();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    repeat (STACK_DEPTH + 3) send_item(OP_PUSH, pick_value());
    repeat (100) send_item(OP_POP, $urandom);
    wait_drained();
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so the
  // block stalls its input; then pause the sender until all results are in.
  task automatic test_backpressure();
    src_gaps_on   = 1'b0;
    sink_gaps_on  = 1'b0;
    sink_hold_req = 300;
    repeat (60) send_item($urandom_range(0, 99) < 70 ? OP_PUSH : OP_POP, pick_value());
    wait_drained();
  endtask

  // Random walk of the fill level: bursts with a push-heavy, balanced or
  // pop-heavy mix. Pops on an empty stack do not count towards the total.
  task automatic test_random_walk(input int n_items, input bit gaps);
    int counted;
    int burst;
    int push_pct;
    logic op;
    counted      = 0;
    src_gaps_on  = gaps;
    sink_gaps_on = gaps;
    while (counted < n_items) begin
      burst = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 50;
        default: push_pct = 25;
      endcase
      repeat (burst) begin
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        if (!(op == OP_POP && shadow_fill == 0)) counted++;
        send_item(op, pick_value());
      end
    end
  endtask

  initial begin
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_backpressure();
    test_random_walk(200, 1'b1);
    // Last stretch runs flat out on both sides.
    test_random_walk(100, 1'b0);

    wait_drained();
    repeat (5) @(posedge clk);
    if (pending_views.size() != 0)
      report_mismatch("results never arrived, count", pending_views.size(), 0);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
